/* src/tile_animation_channel_sequencer_core_assert.svh */
// assertion macros for the tile animation channel sequencer
// no dependencies; included by the top level
`ifndef TILE_ANIMATION_CHANNEL_SEQUENCER_CORE_ASSERT_SVH
`define TILE_ANIMATION_CHANNEL_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication
`define TACS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TACS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/tacs_pkg.sv */
// shared types, mode codes and helpers of the tile animation channel sequencer
// no dependencies
package tacs_pkg;

   localparam int NUM_CHANNELS_DEF = 16;

   localparam int MODE_W    = 3;
   localparam int CHANNEL_W = 4;
   localparam int PERIOD_W  = 8;
   localparam int COUNT_W   = 7;
   localparam int FRAME_W   = 8;

   localparam logic [MODE_W-1:0] MODE_NONE     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LOOP     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FWD_ONCE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_PINGPONG = 3'd3;
   localparam logic [MODE_W-1:0] MODE_REV_ONCE = 3'd4;
   localparam logic [MODE_W-1:0] MODE_REV_LOOP = 3'd5;

   localparam logic [FRAME_W-1:0] PINGPONG_BASE = 8'd2;

   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   // per-channel payload, everything but the mode
   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic [COUNT_W-1:0]  count;
      logic [PERIOD_W-1:0] counter;
      logic [FRAME_W-1:0]  frame;
   } chan_data_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      chan_data_type     data;
   } chan_entry_type;

   // magnitude of a signed 8-bit frame, minus 128 reads as 128
   function automatic logic [FRAME_W-1:0] frame_mag(input logic [FRAME_W-1:0] f);
      frame_mag = f[FRAME_W-1] ? FRAME_W'(~f + 1'b1) : f;
   endfunction

endpackage

/* src/tacs_if.sv */
// valid/ready channel interfaces for the request and response beats
// depends on tacs_pkg
interface tacs_req_if
   import tacs_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic                 action;
   logic [CHANNEL_W-1:0] channel;
   logic [MODE_W-1:0]    anim_mode;
   logic [PERIOD_W-1:0]  ticks_per_frame;
   logic [COUNT_W-1:0]   frame_count;

   modport source (output valid, action, channel, anim_mode, ticks_per_frame, frame_count,
                   input ready);
   modport sink   (input valid, action, channel, anim_mode, ticks_per_frame, frame_count,
                   output ready);
endinterface

interface tacs_rsp_if
   import tacs_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [CHANNEL_W-1:0] out_channel;
   logic [FRAME_W-1:0]   frame_index;
   logic                 last;

   modport source (output valid, out_channel, frame_index, last, input ready);
   modport sink   (input valid, out_channel, frame_index, last, output ready);
endinterface

/* src/tacs_step.sv */
// shared channel step unit: counter advance and frame stepping by mode
// depends on tacs_pkg
module tacs_step
   import tacs_pkg::*;
(
   input  chan_entry_type cur_entry,
   output chan_data_type  nxt_data,
   output logic           stepped
);

   logic [PERIOD_W-1:0] tick_cnt;
   logic                hit;
   logic                go;
   logic [FRAME_W-1:0]  inc;
   logic [FRAME_W-1:0]  dec;
   logic [FRAME_W-1:0]  cnt_ext;
   logic [FRAME_W-1:0]  stepped_frame;

   assign tick_cnt = cur_entry.data.counter + 1'b1;
   assign hit      = (tick_cnt == cur_entry.data.period);
   assign inc      = cur_entry.data.frame + 1'b1;
   assign dec      = cur_entry.data.frame - 1'b1;
   assign cnt_ext  = FRAME_W'(cur_entry.data.count);

   always_comb begin
      go            = 1'b0;
      stepped_frame = cur_entry.data.frame;
      case (cur_entry.mode)
         MODE_LOOP: begin
            go            = 1'b1;
            stepped_frame = (inc == cnt_ext) ? '0 : inc;
         end
         MODE_FWD_ONCE: begin
            go            = (cur_entry.data.frame != FRAME_W'(cnt_ext - 1'b1));
            stepped_frame = inc;
         end
         MODE_PINGPONG: begin
            go            = 1'b1;
            stepped_frame = (inc == cnt_ext) ? FRAME_W'(PINGPONG_BASE - inc) : inc;
         end
         MODE_REV_ONCE: begin
            go            = (cur_entry.data.frame != '0);
            stepped_frame = dec;
         end
         MODE_REV_LOOP: begin
            go            = 1'b1;
            stepped_frame = dec[FRAME_W-1] ? FRAME_W'(cnt_ext - 1'b1) : dec;
         end
         default: begin
            go            = 1'b0;
            stepped_frame = cur_entry.data.frame;
         end
      endcase
   end

   assign stepped = go && hit;

   always_comb begin
      nxt_data = cur_entry.data;
      if (go) begin
         nxt_data.counter = hit ? '0 : tick_cnt;
      end
      if (stepped) begin
         nxt_data.frame = stepped_frame;
      end
   end

endmodule

/* src/tile_animation_channel_sequencer_core.sv */
// tile animation channel sequencer, top level: channel table, walk sequencer, output register
// depends on tacs_pkg, tacs_if, tacs_step and the assertion macro header
// load beat: busy until the output register is free, result then sits in the output register
// tick beat: one channel per cycle through the shared step unit unless a stepping channel stalls
//   on a full held result and output; one result per stepping channel, last on the final one
// reset: synchronous, clears every channel to mode none at once, no clearing pass
`include "tile_animation_channel_sequencer_core_assert.svh"

module tile_animation_channel_sequencer_core
   import tacs_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
   input logic         clock,
   input logic         reset,
   tacs_req_if.sink    req_chan,
   tacs_rsp_if.source  rsp_chan
);

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WALK  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   // channel table: mode is control state, the rest is payload
   logic [MODE_W-1:0] mode_ff [NUM_CHANNELS];
   chan_data_type     data_ff [NUM_CHANNELS];

   // one result held back until we know whether another follows
   logic                 pend_valid_ff, pend_valid_in;
   logic [CHANNEL_W-1:0] pend_channel_ff, pend_channel_in;
   logic [FRAME_W-1:0]   pend_frame_ff, pend_frame_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHANNEL_W-1:0] rsp_channel_ff, rsp_channel_in;
   logic [FRAME_W-1:0]   rsp_frame_ff, rsp_frame_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic               req_fire;
   logic               slot_free;
   logic               load_hit;
   logic [IDX_W-1:0]   load_addr;
   logic [FRAME_W-1:0] start_frame;
   chan_entry_type     cur_entry;
   chan_data_type      nxt_data;
   logic               stepped;
   logic               walk_go;

   // ready whenever idle, even with a response still waiting in the output register
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;

   // loads beyond the table are dropped without a result
   assign load_hit  = req_fire && (req_chan.action == ACTION_LOAD)
                      && (32'(req_chan.channel) < NUM_CHANNELS);
   assign load_addr = IDX_W'(req_chan.channel);

   // forward once and reverse loop start on the last frame
   assign start_frame = (req_chan.anim_mode == MODE_FWD_ONCE ||
                         req_chan.anim_mode == MODE_REV_LOOP)
                        ? FRAME_W'(FRAME_W'(req_chan.frame_count) - 1'b1) : '0;

   // shared step unit sees the channel under the walk index
   assign cur_entry.mode = mode_ff[idx_ff];
   assign cur_entry.data = data_ff[idx_ff];

   tacs_step u_step (
      .cur_entry (cur_entry),
      .nxt_data  (nxt_data),
      .stepped   (stepped)
   );

   // a stepping channel must wait if both the held result and the output are full
   assign walk_go = (state_ff == ST_WALK) && (!stepped || !pend_valid_ff || slot_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            mode_ff[i] <= MODE_NONE;
         end
      end else if (load_hit) begin
         mode_ff[load_addr] <= req_chan.anim_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (load_hit) begin
         data_ff[load_addr].period  <= req_chan.ticks_per_frame;
         data_ff[load_addr].count   <= req_chan.frame_count;
         data_ff[load_addr].counter <= '0;
         data_ff[load_addr].frame   <= start_frame;
      end else if (walk_go) begin
         data_ff[idx_ff] <= nxt_data;
      end
   end

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      pend_valid_in   = pend_valid_ff;
      pend_channel_in = pend_channel_ff;
      pend_frame_in   = pend_frame_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_channel_in  = rsp_channel_ff;
      rsp_frame_in    = rsp_frame_ff;
      rsp_last_in     = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               idx_in = '0;
               if (req_chan.action == ACTION_TICK) begin
                  state_in = ST_WALK;
               end else begin
                  state_in = ST_FLUSH;
                  if (load_hit) begin
                     pend_valid_in   = 1'b1;
                     pend_channel_in = req_chan.channel;
                     pend_frame_in   = frame_mag(start_frame);
                  end
               end
            end
         end
         ST_WALK: begin
            if (walk_go) begin
               if (stepped) begin
                  // a newer result exists, so the held one is not the last
                  if (pend_valid_ff) begin
                     rsp_valid_in   = 1'b1;
                     rsp_channel_in = pend_channel_ff;
                     rsp_frame_in   = pend_frame_ff;
                     rsp_last_in    = 1'b0;
                  end
                  pend_valid_in   = 1'b1;
                  pend_channel_in = CHANNEL_W'(idx_ff);
                  pend_frame_in   = frame_mag(nxt_data.frame);
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_FLUSH;
                  idx_in   = '0;
               end else begin
                  idx_in = IDX_W'(idx_ff + 1'b1);
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_channel_in = pend_channel_ff;
               rsp_frame_in   = pend_frame_ff;
               rsp_last_in    = 1'b1;
               pend_valid_in  = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_channel_ff <= pend_channel_in;
      pend_frame_ff   <= pend_frame_in;
      rsp_channel_ff  <= rsp_channel_in;
      rsp_frame_ff    <= rsp_frame_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_channel = rsp_channel_ff;
   assign rsp_chan.frame_index = rsp_frame_ff;
   assign rsp_chan.last        = rsp_last_ff;

   // nothing may be held back once the sequencer is idle
   `TACS_ASSERT_IMPLY(a_idle_no_pend, clock, reset, state_ff == ST_IDLE, !pend_valid_ff,
      "held result left over in idle")
   // the walk always starts from channel zero
   `TACS_ASSERT_IMPLY(a_idle_idx_zero, clock, reset, state_ff == ST_IDLE, idx_ff == '0,
      "walk index not cleared in idle")
   // an accepted beat always takes the sequencer out of idle
   `TACS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, state_ff != ST_IDLE,
      "sequencer idle right after an accepted beat")

endmodule
